@@ sv/ptc_pkg.sv @@
`timescale 1ns / 1ps

package ptc_pkg;

    // datapath operations
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SHL   = 4'd2,
        OP_SDIVP = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV10 = 4'd5,
        OP_SETLT = 4'd6,
        OP_TSAT  = 4'd7,
        OP_PFIN  = 4'd8
    } op_t;

    // operand sources: scratch registers first, then fixed values
    typedef enum logic [4:0] {
        SRC_R0  = 5'd0,
        SRC_R1  = 5'd1,
        SRC_R2  = 5'd2,
        SRC_R3  = 5'd3,
        SRC_R4  = 5'd4,
        SRC_R5  = 5'd5,
        SRC_R6  = 5'd6,
        SRC_R7  = 5'd7,
        SRC_RAW = 5'd8,
        SRC_TL  = 5'd9,
        SRC_IMM = 5'd10,
        SRC_T1  = 5'd11,
        SRC_T2  = 5'd12,
        SRC_T3  = 5'd13,
        SRC_P1  = 5'd14,
        SRC_P2  = 5'd15,
        SRC_P3  = 5'd16,
        SRC_P4  = 5'd17,
        SRC_P5  = 5'd18,
        SRC_P6  = 5'd19,
        SRC_P7  = 5'd20,
        SRC_P8  = 5'd21,
        SRC_P9  = 5'd22,
        SRC_P10 = 5'd23,
        SRC_P11 = 5'd24
    } src_t;

    localparam int PC_W     = 6;
    localparam int REG_AW   = 3;
    localparam int WORD_W   = 64;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 48;

    localparam logic [CFG_IW-1:0] REG_TEMP_TRIM    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_PRESS_TRIM_A = 2'd1;
    localparam logic [CFG_IW-1:0] REG_PRESS_TRIM_B = 2'd2;
    localparam logic [CFG_IW-1:0] REG_PRESS_TRIM_C = 2'd3;

    localparam logic [PC_W-1:0] TEMP_START  = 6'd0;
    localparam logic [PC_W-1:0] PRESS_START = 6'd12;

    localparam logic [4:0] DIVISOR_TEN = 5'd10;

    typedef struct packed {
        op_t               op;
        logic [REG_AW-1:0] dst;
        src_t              srca;
        src_t              srcb;
        logic [5:0]        shamt;
        logic [15:0]       imm;
    } instr_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   start;
        instr_t ins;
    } ptc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic out_free;
    } ptc_stat_t;

    function automatic instr_t mk(op_t op, logic [REG_AW-1:0] dst, src_t a, src_t b,
                                  logic [5:0] sh, logic [15:0] imm);
        instr_t i;
        i.op    = op;
        i.dst   = dst;
        i.srca  = a;
        i.srcb  = b;
        i.shamt = sh;
        i.imm   = imm;
        return i;
    endfunction

    // microprogram: temperature at TEMP_START, pressure at PRESS_START
    function automatic instr_t prog_rom(logic [PC_W-1:0] pc);
        instr_t i;
        case (pc)
            // d1 = raw - 256*t1
            6'd0:  i = mk(OP_SHL,   3'd0, SRC_T1,  SRC_R0,  6'd8,  16'd0);
            6'd1:  i = mk(OP_SUB,   3'd0, SRC_RAW, SRC_R0,  6'd0,  16'd0);
            6'd2:  i = mk(OP_MUL,   3'd1, SRC_T2,  SRC_R0,  6'd0,  16'd0);
            6'd3:  i = mk(OP_SHL,   3'd1, SRC_R1,  SRC_R0,  6'd18, 16'd0);
            6'd4:  i = mk(OP_MUL,   3'd2, SRC_R0,  SRC_R0,  6'd0,  16'd0);
            6'd5:  i = mk(OP_MUL,   3'd2, SRC_R2,  SRC_T3,  6'd0,  16'd0);
            6'd6:  i = mk(OP_ADD,   3'd1, SRC_R1,  SRC_R2,  6'd0,  16'd0);
            6'd7:  i = mk(OP_SDIVP, 3'd1, SRC_R1,  SRC_R0,  6'd32, 16'd0);
            6'd8:  i = mk(OP_SETLT, 3'd0, SRC_R1,  SRC_R0,  6'd0,  16'd0);
            6'd9:  i = mk(OP_MUL,   3'd2, SRC_R1,  SRC_IMM, 6'd0,  16'd25);
            6'd10: i = mk(OP_SDIVP, 3'd2, SRC_R2,  SRC_R0,  6'd14, 16'd0);
            6'd11: i = mk(OP_TSAT,  3'd0, SRC_R2,  SRC_R0,  6'd0,  16'd0);
            // pressure: offset terms
            6'd12: i = mk(OP_MUL,   3'd0, SRC_TL,  SRC_TL,  6'd0,  16'd0);
            6'd13: i = mk(OP_SDIVP, 3'd1, SRC_R0,  SRC_R0,  6'd6,  16'd0);
            6'd14: i = mk(OP_MUL,   3'd1, SRC_R1,  SRC_TL,  6'd0,  16'd0);
            6'd15: i = mk(OP_SDIVP, 3'd1, SRC_R1,  SRC_R0,  6'd8,  16'd0);
            6'd16: i = mk(OP_MUL,   3'd2, SRC_P8,  SRC_R1,  6'd0,  16'd0);
            6'd17: i = mk(OP_SDIVP, 3'd2, SRC_R2,  SRC_R0,  6'd5,  16'd0);
            6'd18: i = mk(OP_MUL,   3'd3, SRC_P7,  SRC_R0,  6'd0,  16'd0);
            6'd19: i = mk(OP_SHL,   3'd3, SRC_R3,  SRC_R0,  6'd4,  16'd0);
            6'd20: i = mk(OP_MUL,   3'd4, SRC_P6,  SRC_TL,  6'd0,  16'd0);
            6'd21: i = mk(OP_SHL,   3'd4, SRC_R4,  SRC_R0,  6'd22, 16'd0);
            6'd22: i = mk(OP_SHL,   3'd5, SRC_P5,  SRC_R0,  6'd47, 16'd0);
            6'd23: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R2,  6'd0,  16'd0);
            6'd24: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R3,  6'd0,  16'd0);
            6'd25: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R4,  6'd0,  16'd0);
            // sensitivity terms
            6'd26: i = mk(OP_MUL,   3'd2, SRC_P4,  SRC_R1,  6'd0,  16'd0);
            6'd27: i = mk(OP_SDIVP, 3'd2, SRC_R2,  SRC_R0,  6'd5,  16'd0);
            6'd28: i = mk(OP_MUL,   3'd3, SRC_P3,  SRC_R0,  6'd0,  16'd0);
            6'd29: i = mk(OP_SHL,   3'd3, SRC_R3,  SRC_R0,  6'd2,  16'd0);
            6'd30: i = mk(OP_SUB,   3'd4, SRC_P2,  SRC_IMM, 6'd0,  16'd16384);
            6'd31: i = mk(OP_MUL,   3'd4, SRC_R4,  SRC_TL,  6'd0,  16'd0);
            6'd32: i = mk(OP_SHL,   3'd4, SRC_R4,  SRC_R0,  6'd21, 16'd0);
            6'd33: i = mk(OP_SUB,   3'd6, SRC_P1,  SRC_IMM, 6'd0,  16'd16384);
            6'd34: i = mk(OP_SHL,   3'd6, SRC_R6,  SRC_R0,  6'd46, 16'd0);
            6'd35: i = mk(OP_ADD,   3'd6, SRC_R6,  SRC_R2,  6'd0,  16'd0);
            6'd36: i = mk(OP_ADD,   3'd6, SRC_R6,  SRC_R3,  6'd0,  16'd0);
            6'd37: i = mk(OP_ADD,   3'd6, SRC_R6,  SRC_R4,  6'd0,  16'd0);
            // raw-dependent terms
            6'd38: i = mk(OP_SDIVP, 3'd0, SRC_R6,  SRC_R0,  6'd24, 16'd0);
            6'd39: i = mk(OP_MUL,   3'd0, SRC_R0,  SRC_RAW, 6'd0,  16'd0);
            6'd40: i = mk(OP_MUL,   3'd2, SRC_P10, SRC_TL,  6'd0,  16'd0);
            6'd41: i = mk(OP_SHL,   3'd3, SRC_P9,  SRC_R0,  6'd16, 16'd0);
            6'd42: i = mk(OP_ADD,   3'd3, SRC_R2,  SRC_R3,  6'd0,  16'd0);
            6'd43: i = mk(OP_MUL,   3'd3, SRC_R3,  SRC_RAW, 6'd0,  16'd0);
            6'd44: i = mk(OP_SDIVP, 3'd3, SRC_R3,  SRC_R0,  6'd13, 16'd0);
            6'd45: i = mk(OP_DIV10, 3'd3, SRC_R3,  SRC_R0,  6'd0,  16'd0);
            6'd46: i = mk(OP_MUL,   3'd3, SRC_RAW, SRC_R3,  6'd0,  16'd0);
            6'd47: i = mk(OP_SDIVP, 3'd3, SRC_R3,  SRC_R0,  6'd9,  16'd0);
            6'd48: i = mk(OP_MUL,   3'd3, SRC_R3,  SRC_IMM, 6'd0,  16'd10);
            6'd49: i = mk(OP_MUL,   3'd4, SRC_RAW, SRC_RAW, 6'd0,  16'd0);
            6'd50: i = mk(OP_MUL,   3'd4, SRC_P11, SRC_R4,  6'd0,  16'd0);
            6'd51: i = mk(OP_SDIVP, 3'd4, SRC_R4,  SRC_R0,  6'd16, 16'd0);
            6'd52: i = mk(OP_MUL,   3'd4, SRC_R4,  SRC_RAW, 6'd0,  16'd0);
            6'd53: i = mk(OP_SDIVP, 3'd4, SRC_R4,  SRC_R0,  6'd7,  16'd0);
            // final sum
            6'd54: i = mk(OP_SDIVP, 3'd5, SRC_R5,  SRC_R0,  6'd2,  16'd0);
            6'd55: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R0,  6'd0,  16'd0);
            6'd56: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R3,  6'd0,  16'd0);
            6'd57: i = mk(OP_ADD,   3'd5, SRC_R5,  SRC_R4,  6'd0,  16'd0);
            6'd58: i = mk(OP_PFIN,  3'd0, SRC_R5,  SRC_R0,  6'd0,  16'd0);
            default: i = mk(OP_PFIN, 3'd0, SRC_R0, SRC_R0,  6'd0,  16'd0);
        endcase
        return i;
    endfunction

endpackage

@@ sv/pressure_temperature_compensation.sv @@
`timescale 1ns / 1ps
// Barometric temperature / pressure compensation.
// Input channel s_*: s_func selects a temperature (0) or pressure (1) reading,
// s_raw_value carries the 24-bit raw converter word. Output channel m_*: one
// word per input, m_kind echoes the reading type; temperature in 0.01 degree
// (pressure field 0) or pressure in 0.01 Pa (temperature field 0).
// A temperature reading also updates the kept linearized temperature that
// later pressure readings use.
// Trim registers are written through cfg_wr_en / cfg_index / cfg_wr_data,
// index 0 temp_trim, 1..3 press_trim_a..c; the user must write them only
// while no reading is in flight, as the block itself does not enforce this.
// Each microinstruction is a register file read, then an execute step; each
// 64-bit product is formed from partial products on the shared 32x32
// multiplier, and the divide by ten takes extra steps on its own unit. One reading
// is processed at a time; the next is accepted in the cycle after the result
// is loaded.
// The result sits in an output register; when the receiver stalls, the next
// reading is accepted and computed, and waits at its final step for the slot.
// Reset (synchronous, active low) clears the trims and the kept temperature.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [23:0]         s_raw_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic signed [15:0]  m_temperature_centi,
    output logic [23:0]         m_pressure_centi,
    input  logic                cfg_wr_en,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_wr_data
);

    ptc_cmd_t  cmd;
    ptc_stat_t stat;

    ptc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ptc_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_raw_value         (s_raw_value),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wr_data         (cfg_wr_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_centi    (m_pressure_centi)
    );

endmodule

@@ sv/ptc_ram.sv @@
`timescale 1ns / 1ps

module ptc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/ptc_ctrl.sv @@
`timescale 1ns / 1ps

module ptc_ctrl
    import ptc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_func,
    output logic      s_ready,
    input  ptc_stat_t stat,
    output ptc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    instr_t          ins;
    logic            is_final;
    logic            is_multi;
    logic            issue;

    // current microinstruction
    assign ins      = prog_rom(pc_reg);
    assign is_final = (ins.op == OP_TSAT) || (ins.op == OP_PFIN);
    assign is_multi = (ins.op == OP_MUL) || (ins.op == OP_DIV10);
    assign issue    = (state_reg == ST_EXEC) && !(is_final && !stat.out_free);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cmd.load  = s_valid && s_ready;
    assign cmd.start = issue;
    assign cmd.ins   = ins;

    // sequencer
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pc_next    = s_func ? PRESS_START : TEMP_START;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (issue) begin
                    if (is_multi) begin
                        state_next = ST_WAIT;
                    end else if (is_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WAIT: begin
                if (stat.done) begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= TEMP_START;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

@@ sv/ptc_dp.sv @@
`timescale 1ns / 1ps

module ptc_dp
    import ptc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ptc_cmd_t            cmd,
    output ptc_stat_t           stat,
    input  logic [23:0]         s_raw_value,
    input  logic                cfg_wr_en,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_wr_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic signed [15:0]  m_temperature_centi,
    output logic [23:0]         m_pressure_centi
);

    // trim registers and kept temperature
    logic [39:0] temp_trim_reg;
    logic [47:0] press_trim_a_reg;
    logic [47:0] press_trim_b_reg;
    logic [31:0] press_trim_c_reg;
    logic [31:0] linear_temp_reg;
    logic [23:0] raw_reg;

    // scratch register file
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [WORD_W-1:0] rf_wdata;
    logic [WORD_W-1:0] rf_rdata_a, rf_rdata_b;

    logic [WORD_W-1:0] opa, opb;
    logic [WORD_W-1:0] alu_res;
    logic [WORD_W-1:0] div_mask;
    logic              alu_write;

    // multiply unit
    logic              mul_busy_reg;
    logic [1:0]        mul_cnt_reg;
    logic [WORD_W-1:0] op_a_reg, op_b_reg;
    logic [REG_AW-1:0] dst_reg;
    logic [31:0]       mul_x, mul_y;
    logic [63:0]       prod_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       mul_res;
    logic              mul_done;

    // divide-by-ten unit
    logic              div_busy_reg;
    logic [2:0]        div_cnt_reg;
    logic [63:0]       div_x_reg;
    logic [63:0]       div_q_reg;
    logic [63:0]       div_q_next;
    logic [4:0]        div_r_reg;
    logic              div_neg_reg;
    logic [63:0]       div_q_fix;
    logic [63:0]       div_res;
    logic              div_done;

    // result formatting
    logic signed [15:0] tsat;
    logic [22:0]        p_hi;
    logic [44:0]        p_lo;
    logic [44:0]        p_lo25;
    logic [28:0]        p_sum;
    logic [23:0]        psat;
    logic               out_load;
    logic               m_valid_reg;
    logic               m_kind_reg;
    logic signed [15:0] m_temp_reg;
    logic [23:0]        m_press_reg;

    function automatic logic [63:0] sx8(logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // fixed operand values
    function automatic logic [63:0] src_val(src_t s, logic [63:0] rf, logic [15:0] imm,
                                            logic [23:0] raw, logic [31:0] lt,
                                            logic [39:0] tt, logic [47:0] pa,
                                            logic [47:0] pb, logic [31:0] pc);
        logic [63:0] v;
        case (s)
            SRC_RAW: v = {40'd0, raw};
            SRC_TL:  v = {{32{lt[31]}}, lt};
            SRC_IMM: v = {48'd0, imm};
            SRC_T1:  v = {48'd0, tt[15:0]};
            SRC_T2:  v = {48'd0, tt[31:16]};
            SRC_T3:  v = sx8(tt[39:32]);
            SRC_P1:  v = sx16(pa[15:0]);
            SRC_P2:  v = sx16(pa[31:16]);
            SRC_P3:  v = sx8(pa[39:32]);
            SRC_P4:  v = sx8(pa[47:40]);
            SRC_P5:  v = {48'd0, pb[15:0]};
            SRC_P6:  v = {48'd0, pb[31:16]};
            SRC_P7:  v = sx8(pb[39:32]);
            SRC_P8:  v = sx8(pb[47:40]);
            SRC_P9:  v = sx16(pc[15:0]);
            SRC_P10: v = sx8(pc[23:16]);
            SRC_P11: v = sx8(pc[31:24]);
            default: v = rf;
        endcase
        return v;
    endfunction

    ptc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (1 << REG_AW)
    ) u_rf (
        .aclk    (aclk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (cmd.ins.srca[REG_AW-1:0]),
        .raddr_b (cmd.ins.srcb[REG_AW-1:0]),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b)
    );

    // operand select
    assign opa = src_val(cmd.ins.srca, rf_rdata_a, cmd.ins.imm, raw_reg, linear_temp_reg,
                         temp_trim_reg, press_trim_a_reg, press_trim_b_reg,
                         press_trim_c_reg);
    assign opb = src_val(cmd.ins.srcb, rf_rdata_b, cmd.ins.imm, raw_reg, linear_temp_reg,
                         temp_trim_reg, press_trim_a_reg, press_trim_b_reg,
                         press_trim_c_reg);

    // combinational alu, power-of-two divide truncates toward zero
    assign div_mask = (64'd1 << cmd.ins.shamt) - 64'd1;
    always_comb begin
        alu_res   = opa + opb;
        alu_write = 1'b0;
        case (cmd.ins.op)
            OP_ADD: begin
                alu_res   = opa + opb;
                alu_write = 1'b1;
            end
            OP_SUB: begin
                alu_res   = opa - opb;
                alu_write = 1'b1;
            end
            OP_SHL: begin
                alu_res   = opa << cmd.ins.shamt;
                alu_write = 1'b1;
            end
            OP_SDIVP: begin
                alu_res   = 64'($signed(opa + (opa[63] ? div_mask : 64'd0)) >>> cmd.ins.shamt);
                alu_write = 1'b1;
            end
            default: begin
                alu_write = 1'b0;
            end
        endcase
    end

    // multiply: three 32x32 partial products, low 64 bits kept
    assign mul_x    = (mul_cnt_reg == 2'd2) ? op_a_reg[63:32] : op_a_reg[31:0];
    assign mul_y    = (mul_cnt_reg == 2'd1) ? op_b_reg[63:32] : op_b_reg[31:0];
    assign mul_res  = acc_reg + {prod_reg[31:0], 32'd0};
    assign mul_done = mul_busy_reg && (mul_cnt_reg == 2'd3);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_x * mul_y;
        if (mul_cnt_reg == 2'd1) begin
            acc_reg <= prod_reg;
        end else if (mul_cnt_reg == 2'd2) begin
            acc_reg <= mul_res;
        end
        if (cmd.start) begin
            op_a_reg <= opa;
            op_b_reg <= opb;
            dst_reg  <= cmd.ins.dst;
        end
    end

    // divide by ten on the magnitude: shift-and-add estimate of x*0.8,
    // scaled down by 8, then a remainder check adds the missing one
    always_comb begin
        div_q_next = div_q_reg;
        case (div_cnt_reg)
            3'd0: div_q_next = (div_x_reg >> 1) + (div_x_reg >> 2);
            3'd1: div_q_next = div_q_reg + (div_q_reg >> 4);
            3'd2: div_q_next = div_q_reg + (div_q_reg >> 8);
            3'd3: div_q_next = div_q_reg + (div_q_reg >> 16);
            3'd4: div_q_next = div_q_reg + (div_q_reg >> 32);
            3'd5: div_q_next = div_q_reg >> 3;
            default: div_q_next = div_q_reg;
        endcase
    end

    assign div_q_fix = div_q_reg + {63'd0, (div_r_reg >= DIVISOR_TEN)};
    assign div_res   = div_neg_reg ? (64'd0 - div_q_fix) : div_q_fix;
    assign div_done  = div_busy_reg && (div_cnt_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (cmd.start && (cmd.ins.op == OP_DIV10)) begin
            div_x_reg   <= opa[63] ? (64'd0 - opa) : opa;
            div_neg_reg <= opa[63];
        end else if (div_busy_reg) begin
            div_q_reg <= div_q_next;
            if (div_cnt_reg == 3'd6) begin
                div_r_reg <= 5'(div_x_reg - ((div_q_reg << 3) + (div_q_reg << 1)));
            end
        end
    end

    // unit control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= 2'd0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= 3'd0;
        end else begin
            if (cmd.start && (cmd.ins.op == OP_MUL)) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= 2'd0;
            end else if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
                if (mul_done) begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (cmd.start && (cmd.ins.op == OP_DIV10)) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 3'd0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
                if (div_done) begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    // register file write
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = dst_reg;
        rf_wdata = mul_res;
        if (mul_done) begin
            rf_we = 1'b1;
        end else if (div_done) begin
            rf_we    = 1'b1;
            rf_wdata = div_res;
        end else if (cmd.start && alu_write) begin
            rf_we    = 1'b1;
            rf_waddr = cmd.ins.dst;
            rf_wdata = alu_res;
        end
    end

    assign stat.done     = mul_done || div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    // configuration, raw word and kept temperature
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg    <= '0;
            press_trim_a_reg <= '0;
            press_trim_b_reg <= '0;
            press_trim_c_reg <= '0;
            linear_temp_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEMP_TRIM:    temp_trim_reg    <= cfg_wr_data[39:0];
                    REG_PRESS_TRIM_A: press_trim_a_reg <= cfg_wr_data[47:0];
                    REG_PRESS_TRIM_B: press_trim_b_reg <= cfg_wr_data[47:0];
                    REG_PRESS_TRIM_C: press_trim_c_reg <= cfg_wr_data[31:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.start && (cmd.ins.op == OP_SETLT)) begin
                linear_temp_reg <= opa[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_reg <= s_raw_value;
        end
    end

    // temperature saturation
    always_comb begin
        if ($signed(opa) > 64'sd32767) begin
            tsat = 16'sh7fff;
        end else if ($signed(opa) < -64'sd32768) begin
            tsat = -16'sh8000;
        end else begin
            tsat = opa[15:0];
        end
    end

    // pressure scale: floor(sum * 25 / 2^40), saturated
    assign p_hi   = opa[62:40];
    assign p_lo   = {5'd0, opa[39:0]};
    assign p_lo25 = (p_lo << 4) + (p_lo << 3) + p_lo;
    assign p_sum  = ({6'd0, p_hi} << 4) + ({6'd0, p_hi} << 3) + {6'd0, p_hi}
                  + {24'd0, p_lo25[44:40]};
    always_comb begin
        if (opa[63]) begin
            psat = 24'd0;
        end else if (p_sum > 29'h0ff_ffff) begin
            psat = 24'hff_ffff;
        end else begin
            psat = p_sum[23:0];
        end
    end

    // output word register
    assign out_load = cmd.start && ((cmd.ins.op == OP_TSAT) || (cmd.ins.op == OP_PFIN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (cmd.ins.op == OP_TSAT) begin
                m_kind_reg  <= 1'b0;
                m_temp_reg  <= tsat;
                m_press_reg <= 24'd0;
            end else begin
                m_kind_reg  <= 1'b1;
                m_temp_reg  <= 16'sd0;
                m_press_reg <= psat;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_kind              = m_kind_reg;
    assign m_temperature_centi = m_temp_reg;
    assign m_pressure_centi    = m_press_reg;

    // checks
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_busy_reg && div_busy_reg))
        else $error("multiply and divide units busy together");

    a_no_issue_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (!mul_busy_reg && !div_busy_reg))
        else $error("operation issued while a unit is busy");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

endmodule
